/* src/bqj_pkg.sv */
package bqj_pkg;

    localparam int FRAC_BITS = 16;
    localparam int CW = 32;
    localparam int ZW = 18;
    localparam int EW = 40;
    localparam int DW = 48;
    localparam int NW = EW + FRAC_BITS;
    localparam int QD = 4;

    typedef struct packed {
        logic signed [CW-1:0] x0, x1, x2, x3, y0, y1, y2, y3;
        logic signed [ZW-1:0] z1, z2;
    } bqj_in_t;

    typedef struct packed {
        logic signed [EW-1:0] a, b, c, d;
        logic [DW-1:0] adet;
        logic dneg;
    } bqj_mid_t;

    typedef struct packed {
        logic signed [EW-1:0] a, b, c, d;
        logic [DW-1:0] adet;
        logic signed [EW-1:0] i0, i1, i2, i3;
        logic degen;
    } bqj_out_t;

    function automatic logic signed [EW-1:0] clamp40(input logic neg,
                                                     input logic [95:0] m);
        logic signed [EW-1:0] r;
        if (neg) begin
            if (m > 96'(64'd1 << (EW-1))) r = {1'b1, {(EW-1){1'b0}}};
            else r = EW'(-$signed({1'b0, m[EW-1:0]}));
        end else begin
            if (m > 96'((64'd1 << (EW-1)) - 1)) r = {1'b0, {(EW-1){1'b1}}};
            else r = EW'(m);
        end
        return r;
    endfunction

endpackage

/* src/bilinear_quad_jacobian.sv */
// Path: the Jacobian pipeline, then the queue, then the bit-per-stage divider
// pipeline. Throughput: one item per cycle unless the output stalls; each
// pipeline stage holds one item and the queue holds up to four.
// Reset: aresetn, synchronous, active low, clears all valid flags and the queue.
// Data registers are not reset.
module bilinear_quad_jacobian (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // corner_x0..x3, corner_y0..y3, ref_zeta1, ref_zeta2 from bit 0, padded
    input  logic [295:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // dx_dz1, dx_dz2, dy_dz1, dy_dz2, abs_det, dz1_dx, dz1_dy, dz2_dx,
    // dz2_dy, degenerate from bit 0, padded
    output logic [375:0] m_tdata
);
    import bqj_pkg::*;

    // The front computes the Jacobian and determinant, the queue decouples it
    // from the back, which forms the four inverse entries by long division.
    bqj_in_t din;
    assign din.x0 = s_tdata[31:0];    assign din.x1 = s_tdata[63:32];
    assign din.x2 = s_tdata[95:64];   assign din.x3 = s_tdata[127:96];
    assign din.y0 = s_tdata[159:128]; assign din.y1 = s_tdata[191:160];
    assign din.y2 = s_tdata[223:192]; assign din.y3 = s_tdata[255:224];
    assign din.z1 = s_tdata[273:256]; assign din.z2 = s_tdata[291:274];

    logic fv, fr, qv, qr;
    bqj_mid_t fd, qd;
    bqj_out_t od;

    bqj_front u_front (.aclk, .aresetn, .in_valid(s_tvalid), .in_ready(s_tready),
        .in_data(din), .mid_valid(fv), .mid_ready(fr), .mid_data(fd));
    bqj_fifo u_fifo (.aclk, .aresetn, .wr_valid(fv), .wr_ready(fr), .wr_data(fd),
        .rd_valid(qv), .rd_ready(qr), .rd_data(qd));
    bqj_divider u_div (.aclk, .aresetn, .in_valid(qv), .in_ready(qr), .in_data(qd),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_data(od));

    assign m_tdata = {7'd0, od.degen, od.i3, od.i2, od.i1, od.i0, od.adet,
                      od.d, od.c, od.b, od.a};
endmodule

/* src/bqj_front.sv */
module bqj_front (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  bqj_pkg::bqj_in_t in_data,
    output logic mid_valid,
    input  logic mid_ready,
    output bqj_pkg::bqj_mid_t mid_data
);
    import bqj_pkg::*;

    // Five-stage pipeline: products, quarter rounding, partial determinant
    // products, determinant sum, determinant rounding. The whole pipe advances
    // when its tail may move.
    localparam int S = 5;
    logic [S-1:0] v_reg;
    logic adv;
    assign adv = !v_reg[S-1] || mid_ready;
    assign in_ready = adv;
    assign mid_valid = v_reg[S-1];

    logic signed [51:0] p_reg [8];
    logic signed [EW-1:0] a_reg, b_reg, c_reg, d_reg;
    logic signed [EW-1:0] a2_reg, b2_reg, c2_reg, d2_reg;
    logic signed [EW-1:0] a3_reg, b3_reg, c3_reg, d3_reg;
    logic signed [60:0] adl_reg, bcl_reg;
    logic signed [59:0] adh_reg, bch_reg;
    logic signed [80:0] ds_reg;
    bqj_mid_t m_reg;

    logic signed [ZW:0] omz1, opz1, omz2, opz2;
    logic signed [CW:0] dx10, dx32, dx20, dx31, dy10, dy32, dy20, dy31;
    assign omz1 = (ZW+1)'(1 << FRAC_BITS) - in_data.z1;
    assign opz1 = (ZW+1)'(1 << FRAC_BITS) + in_data.z1;
    assign omz2 = (ZW+1)'(1 << FRAC_BITS) - in_data.z2;
    assign opz2 = (ZW+1)'(1 << FRAC_BITS) + in_data.z2;
    assign dx10 = in_data.x1 - in_data.x0;
    assign dx32 = in_data.x3 - in_data.x2;
    assign dx20 = in_data.x2 - in_data.x0;
    assign dx31 = in_data.x3 - in_data.x1;
    assign dy10 = in_data.y1 - in_data.y0;
    assign dy32 = in_data.y3 - in_data.y2;
    assign dy20 = in_data.y2 - in_data.y0;
    assign dy31 = in_data.y3 - in_data.y1;

    function automatic logic signed [EW-1:0] qround(input logic signed [52:0] s);
        logic [52:0] m;
        m = s[52] ? 53'(-s) : 53'(s);
        m = (m + 53'(1 << (FRAC_BITS+1))) >> (FRAC_BITS+2);
        return clamp40(s[52], 96'(m));
    endfunction

    // The determinant products are split on the second factor into a low
    // unsigned half and a high signed half, so no multiplier exceeds 40 by 21.
    logic signed [60:0] adl, bcl;
    logic signed [59:0] adh, bch;
    assign adl = a_reg * $signed({1'b0, d_reg[19:0]});
    assign adh = a_reg * $signed(d_reg[EW-1:20]);
    assign bcl = b_reg * $signed({1'b0, c_reg[19:0]});
    assign bch = b_reg * $signed(c_reg[EW-1:20]);

    logic signed [80:0] dsum;
    assign dsum = ((81'(adh_reg) - 81'(bch_reg)) <<< 20) + (81'(adl_reg) - 81'(bcl_reg));

    logic [80:0] dmag, dr;
    assign dmag = ds_reg[80] ? 81'(-ds_reg) : 81'(ds_reg);
    assign dr = (dmag + 81'(1 << (FRAC_BITS-1))) >> FRAC_BITS;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (adv) begin
            v_reg <= {v_reg[S-2:0], in_valid};
        end
        if (adv) begin
            p_reg[0] <= 52'(dx10 * omz2); p_reg[1] <= 52'(dx32 * opz2);
            p_reg[2] <= 52'(dx20 * omz1); p_reg[3] <= 52'(dx31 * opz1);
            p_reg[4] <= 52'(dy10 * omz2); p_reg[5] <= 52'(dy32 * opz2);
            p_reg[6] <= 52'(dy20 * omz1); p_reg[7] <= 52'(dy31 * opz1);
            a_reg <= qround(53'(p_reg[0]) + 53'(p_reg[1]));
            b_reg <= qround(53'(p_reg[2]) + 53'(p_reg[3]));
            c_reg <= qround(53'(p_reg[4]) + 53'(p_reg[5]));
            d_reg <= qround(53'(p_reg[6]) + 53'(p_reg[7]));
            adl_reg <= adl; adh_reg <= adh;
            bcl_reg <= bcl; bch_reg <= bch;
            a2_reg <= a_reg; b2_reg <= b_reg; c2_reg <= c_reg; d2_reg <= d_reg;
            ds_reg <= dsum;
            a3_reg <= a2_reg; b3_reg <= b2_reg; c3_reg <= c2_reg; d3_reg <= d2_reg;
            m_reg.a <= a3_reg; m_reg.b <= b3_reg;
            m_reg.c <= c3_reg; m_reg.d <= d3_reg;
            m_reg.dneg <= ds_reg[80];
            m_reg.adet <= (dr > 81'({DW{1'b1}})) ? {DW{1'b1}} : dr[DW-1:0];
        end
    end
    assign mid_data = m_reg;
endmodule

/* src/bqj_fifo.sv */
module bqj_fifo (
    input  logic aclk,
    input  logic aresetn,
    input  logic wr_valid,
    output logic wr_ready,
    input  bqj_pkg::bqj_mid_t wr_data,
    output logic rd_valid,
    input  logic rd_ready,
    output bqj_pkg::bqj_mid_t rd_data
);
    import bqj_pkg::*;

    bqj_mid_t mem [QD];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg;
    logic wr, rd;
    assign wr_ready = cnt_reg != 3'(QD);
    assign rd_valid = cnt_reg != 3'd0;
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;
    assign rd_data = mem[rp_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end else begin
            if (wr) wp_reg <= wp_reg + 2'd1;
            if (rd) rp_reg <= rp_reg + 2'd1;
            cnt_reg <= cnt_reg + 3'(wr) - 3'(rd);
        end
        if (wr) mem[wp_reg] <= wr_data;
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 3'(QD)) else $error("queue overflow");
    a_empty_nord: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg == 3'd0 |-> !rd) else $error("read from empty queue");
    a_cnt_step: assert property (@(posedge aclk) disable iff (!aresetn)
        wr && !rd |=> cnt_reg == $past(cnt_reg) + 3'd1) else $error("count slip");
endmodule

/* src/bqj_divider.sv */
module bqj_divider (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  bqj_pkg::bqj_mid_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output bqj_pkg::bqj_out_t out_data
);
    import bqj_pkg::*;

    // Pipelined restoring division: four quotients, one bit per stage.
    localparam int NS = NW;
    typedef struct packed {
        logic [NW-1:0] q0, q1, q2, q3;
        logic [NW:0] r0, r1, r2, r3;
        logic [NW-1:0] n0, n1, n2, n3;
        logic [DW-1:0] den;
        logic s0, s1, s2, s3;
        bqj_mid_t m;
    } stg_t;

    stg_t st_reg [NS+1];
    logic [NS:0] v_reg;
    logic adv;
    assign adv = !v_reg[NS] || out_ready;
    assign in_ready = adv;
    assign out_valid = v_reg[NS];

    function automatic logic [NW-1:0] nmag(input logic signed [EW-1:0] v);
        logic [EW:0] m;
        m = v[EW-1] ? (EW+1)'(-$signed({v[EW-1], v})) : (EW+1)'(v);
        return NW'(m) << FRAC_BITS;
    endfunction

    stg_t s0;
    always_comb begin
        s0 = '0;
        s0.m = in_data;
        s0.den = in_data.adet;
        s0.n0 = nmag(in_data.d);
        s0.n1 = nmag(in_data.b);
        s0.n2 = nmag(in_data.c);
        s0.n3 = nmag(in_data.a);
        s0.s0 = in_data.d[EW-1] != in_data.dneg;
        s0.s1 = !in_data.b[EW-1] && in_data.b != '0 ? !in_data.dneg
                : (in_data.b == '0 ? 1'b0 : in_data.dneg);
        s0.s2 = !in_data.c[EW-1] && in_data.c != '0 ? !in_data.dneg
                : (in_data.c == '0 ? 1'b0 : in_data.dneg);
        s0.s3 = in_data.a[EW-1] != in_data.dneg;
        // Rounding: the remainder starts at zero; half the divisor is added to the numerator instead.
        s0.r0 = '0; s0.r1 = '0; s0.r2 = '0; s0.r3 = '0;
    end

    function automatic void dstep(input logic [NW:0] r, input logic [NW-1:0] n,
                                  input logic [NW-1:0] q, input logic [DW-1:0] dv,
                                  output logic [NW:0] ro, output logic [NW-1:0] no,
                                  output logic [NW-1:0] qo);
        logic [NW+1:0] t;
        t = {r, n[NW-1]} ;
        no = n << 1;
        if (t >= (NW+2)'(dv)) begin
            ro = (NW+1)'(t - (NW+2)'(dv)); qo = {q[NW-2:0], 1'b1};
        end else begin
            ro = (NW+1)'(t); qo = {q[NW-2:0], 1'b0};
        end
    endfunction

    // Numerator is n + den/2: prepend by adding half to the final remainder
    // compare is not exact, so bias the numerator up front instead.
    function automatic logic [NW-1:0] bias(input logic [NW-1:0] n,
                                           input logic [DW-1:0] dv);
        return n + NW'(dv >> 1);
    endfunction

    stg_t nx [NS];
    always_comb begin
        for (int i = 0; i < NS; i++) begin
            nx[i] = st_reg[i];
            dstep(st_reg[i].r0, st_reg[i].n0, st_reg[i].q0, st_reg[i].den,
                  nx[i].r0, nx[i].n0, nx[i].q0);
            dstep(st_reg[i].r1, st_reg[i].n1, st_reg[i].q1, st_reg[i].den,
                  nx[i].r1, nx[i].n1, nx[i].q1);
            dstep(st_reg[i].r2, st_reg[i].n2, st_reg[i].q2, st_reg[i].den,
                  nx[i].r2, nx[i].n2, nx[i].q2);
            dstep(st_reg[i].r3, st_reg[i].n3, st_reg[i].q3, st_reg[i].den,
                  nx[i].r3, nx[i].n3, nx[i].q3);
        end
    end

    stg_t sb;
    always_comb begin
        sb = s0;
        sb.n0 = bias(s0.n0, s0.den); sb.n1 = bias(s0.n1, s0.den);
        sb.n2 = bias(s0.n2, s0.den); sb.n3 = bias(s0.n3, s0.den);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (adv) begin
            v_reg <= {v_reg[NS-1:0], in_valid};
        end
        if (adv) begin
            st_reg[0] <= sb;
            for (int i = 0; i < NS; i++) st_reg[i+1] <= nx[i];
        end
    end

    stg_t f;
    logic dz;
    assign f = st_reg[NS];
    assign dz = f.den == '0;
    always_comb begin
        out_data.a = f.m.a; out_data.b = f.m.b;
        out_data.c = f.m.c; out_data.d = f.m.d;
        out_data.adet = f.m.adet;
        out_data.degen = dz;
        out_data.i0 = dz ? '0 : clamp40(f.s0, 96'(f.q0));
        out_data.i1 = dz ? '0 : clamp40(f.s1, 96'(f.q1));
        out_data.i2 = dz ? '0 : clamp40(f.s2, 96'(f.q2));
        out_data.i3 = dz ? '0 : clamp40(f.s3, 96'(f.q3));
    end

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && !out_ready |=> out_valid) else $error("result dropped");
    a_deg: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && dz |-> out_data.i0 == '0) else $error("degenerate inverse");
    a_nodz: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid |-> out_data.degen == (out_data.adet == '0)) else $error("flag");
endmodule
